FILE: hw/rtl/tsc_pkg.sv
package tsc_pkg;

  localparam int WORD_CAPACITY_DEF = 512;
  localparam int COUNT_W = 32;
  localparam int BYTE_W = 8;
  localparam int INDEX_W = 9;
  localparam int LONG_W = 9;
  localparam int CMD_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_UC_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_BIT   = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_A     = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_E     = 8'h65;
  localparam logic [BYTE_W-1:0] CHAR_I     = 8'h69;
  localparam logic [BYTE_W-1:0] CHAR_O     = 8'h6F;
  localparam logic [BYTE_W-1:0] CHAR_U     = 8'h75;

  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE = 2'd0,
    CMD_EOS  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e_t;

  typedef struct packed {
    logic is_space;
    logic is_aeiou;
    logic is_upper;
    logic is_lf;
  } byte_class_t;

  typedef struct packed {
    logic fire;
    logic is_byte;
    logic is_eos;
    logic is_read;
  } step_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

endpackage

FILE: hw/rtl/tsc_classify.sv
module tsc_classify (
  input  logic [tsc_pkg::BYTE_W-1:0] data_byte,
  output tsc_pkg::byte_class_t       cls
);

  logic                      upper;
  logic [tsc_pkg::BYTE_W-1:0] lower;

  assign upper = (data_byte >= tsc_pkg::CHAR_UC_A) && (data_byte <= tsc_pkg::CHAR_UC_Z);
  assign lower = upper ? (data_byte | tsc_pkg::CASE_BIT) : data_byte;

  always_comb begin
    cls.is_space = (data_byte == tsc_pkg::CHAR_SPACE) ||
                   ((data_byte >= tsc_pkg::CHAR_TAB) && (data_byte <= tsc_pkg::CHAR_CR));
    cls.is_aeiou = (lower == tsc_pkg::CHAR_A) || (lower == tsc_pkg::CHAR_E) ||
                   (lower == tsc_pkg::CHAR_I) || (lower == tsc_pkg::CHAR_O) ||
                   (lower == tsc_pkg::CHAR_U);
    cls.is_upper = upper;
    cls.is_lf    = (data_byte == tsc_pkg::CHAR_LF);
  end

endmodule

FILE: hw/rtl/tsc_counters.sv
module tsc_counters (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tsc_pkg::step_t                step,
  input  tsc_pkg::byte_class_t          cls,
  input  logic                          word_close,
  output logic [tsc_pkg::COUNT_W-1:0]   lines_seen,
  output logic [tsc_pkg::COUNT_W-1:0]   words_seen,
  output logic [tsc_pkg::COUNT_W-1:0]   vowels_seen,
  output logic [tsc_pkg::COUNT_W-1:0]   uppers_seen
);

  logic [tsc_pkg::COUNT_W-1:0] line_total_r, line_total_nxt;
  logic [tsc_pkg::COUNT_W-1:0] word_total_r, word_total_nxt;
  logic [tsc_pkg::COUNT_W-1:0] vowel_total_r, vowel_total_nxt;
  logic [tsc_pkg::COUNT_W-1:0] upper_total_r, upper_total_nxt;
  logic                        line_open_r, line_open_nxt;
  logic                        take_byte;

  assign take_byte = step.fire && step.is_byte;

  always_comb begin
    line_total_nxt  = line_total_r;
    word_total_nxt  = word_total_r;
    vowel_total_nxt = vowel_total_r;
    upper_total_nxt = upper_total_r;
    line_open_nxt   = line_open_r;
    if (word_close) begin
      word_total_nxt = tsc_pkg::sat_inc(word_total_r);
    end
    if (take_byte) begin
      if (cls.is_aeiou) begin
        vowel_total_nxt = tsc_pkg::sat_inc(vowel_total_r);
      end
      if (cls.is_upper) begin
        upper_total_nxt = tsc_pkg::sat_inc(upper_total_r);
      end
      if (cls.is_lf) begin
        line_total_nxt = tsc_pkg::sat_inc(line_total_r);
        line_open_nxt  = 1'b0;
      end else begin
        line_open_nxt = 1'b1;
      end
    end
    if (step.fire && step.is_eos && line_open_r) begin
      line_total_nxt = tsc_pkg::sat_inc(line_total_r);
      line_open_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_total_r  <= '0;
      word_total_r  <= '0;
      vowel_total_r <= '0;
      upper_total_r <= '0;
      line_open_r   <= 1'b0;
    end else begin
      line_total_r  <= line_total_nxt;
      word_total_r  <= word_total_nxt;
      vowel_total_r <= vowel_total_nxt;
      upper_total_r <= upper_total_nxt;
      line_open_r   <= line_open_nxt;
    end
  end

  assign lines_seen  = line_total_r;
  assign words_seen  = word_total_r;
  assign vowels_seen = vowel_total_r;
  assign uppers_seen = upper_total_r;

  a_word_moves_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    (word_total_r != $past(word_total_r)) |-> $past(word_close))
    else $error("word count changed without a closed word");

endmodule

FILE: hw/rtl/tsc_word_store.sv
module tsc_word_store #(
  parameter int WORD_CAPACITY = tsc_pkg::WORD_CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tsc_pkg::step_t                step,
  input  tsc_pkg::byte_class_t          cls,
  input  logic [tsc_pkg::BYTE_W-1:0]    data_byte,
  input  logic [tsc_pkg::INDEX_W-1:0]   char_index,
  output logic                          word_close,
  output logic [tsc_pkg::LONG_W-1:0]    longest_length,
  output logic [tsc_pkg::BYTE_W-1:0]    word_char
);

  localparam int LEN_W = (WORD_CAPACITY > 1) ? $clog2(WORD_CAPACITY) : 1;
  localparam int ADDR_W = LEN_W + 1;
  localparam int DEPTH = 2 ** ADDR_W;
  localparam int CMP_W = (LEN_W > tsc_pkg::INDEX_W) ? LEN_W : tsc_pkg::INDEX_W;
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(WORD_CAPACITY - 1);

  logic [tsc_pkg::BYTE_W-1:0] mem [DEPTH];

  logic             inside_word_r, inside_word_nxt;
  logic [LEN_W-1:0] current_length_r, current_length_nxt;
  logic [LEN_W-1:0] best_length_r, best_length_nxt;
  logic             best_bank_r, best_bank_nxt;
  logic             rd_hit_r, rd_hit_nxt;
  logic [tsc_pkg::BYTE_W-1:0] rd_data_r;

  logic              append;
  logic              store;
  logic [LEN_W-1:0]  len_base;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [CMP_W-1:0]  index_ext;
  logic [CMP_W-1:0]  best_ext;
  logic              rd_en;

  assign word_close = step.fire && inside_word_r &&
                      ((step.is_byte && cls.is_space) || step.is_eos);
  assign append     = step.fire && step.is_byte && !cls.is_space;
  assign len_base   = inside_word_r ? current_length_r : '0;
  assign store      = append && (len_base < LEN_LIMIT);
  assign wr_addr    = {~best_bank_r, len_base};

  assign index_ext  = CMP_W'(char_index);
  assign best_ext   = CMP_W'(best_length_r);
  assign rd_hit_nxt = step.is_read && (index_ext < best_ext);
  assign rd_en      = step.fire && rd_hit_nxt;
  assign rd_addr    = {best_bank_r, index_ext[LEN_W-1:0]};

  always_comb begin
    inside_word_nxt    = inside_word_r;
    current_length_nxt = current_length_r;
    best_length_nxt    = best_length_r;
    best_bank_nxt      = best_bank_r;
    if (word_close) begin
      inside_word_nxt    = 1'b0;
      current_length_nxt = '0;
      if (current_length_r > best_length_r) begin
        best_length_nxt = current_length_r;
        best_bank_nxt   = ~best_bank_r;
      end
    end else if (append) begin
      inside_word_nxt    = 1'b1;
      current_length_nxt = store ? len_base + LEN_W'(1) : len_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_word_r    <= 1'b0;
      current_length_r <= '0;
      best_length_r    <= '0;
      best_bank_r      <= 1'b0;
      rd_hit_r         <= 1'b0;
    end else begin
      inside_word_r    <= inside_word_nxt;
      current_length_r <= current_length_nxt;
      best_length_r    <= best_length_nxt;
      best_bank_r      <= best_bank_nxt;
      if (step.fire) begin
        rd_hit_r <= rd_hit_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem[wr_addr] <= data_byte;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign longest_length = best_ext[tsc_pkg::LONG_W-1:0];
  assign word_char      = rd_hit_r ? rd_data_r : '0;

  a_length_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    (current_length_r != '0) |-> inside_word_r)
    else $error("word length held outside a word");

  a_swap_grows_best: assert property (@(posedge clk) disable iff (!rst_n)
    (best_bank_r != $past(best_bank_r)) |-> (best_length_r > $past(best_length_r)))
    else $error("banks swapped without a longer word");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    store |-> (!word_close && (best_length_r <= LEN_LIMIT)))
    else $error("write while closing a word or best length out of range");

endmodule

FILE: hw/rtl/text_statistics_counter.sv
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_ready  | in_command, in_data_byte, in_char_index
// out_    | output    | out_valid / out_ready| out_lines_seen, out_words_seen,
//         |           |                      | out_vowels_seen, out_uppers_seen,
//         |           |                      | out_longest_length, out_word_char
//
// Each input transaction yields exactly one output transaction, in the cycle after it is accepted.
// One transaction per cycle is sustained while out_ready is high; the word memory
// has one write and one registered read port, and the counters are registered.
// in_ready is low only while a result is held and out_ready is low.
// Reset is synchronous and active low; the word memory needs no clearing pass.
module text_statistics_counter #(
  parameter int WORD_CAPACITY = tsc_pkg::WORD_CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tsc_pkg::CMD_W-1:0]     in_command,
  input  logic [tsc_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic [tsc_pkg::INDEX_W-1:0]   in_char_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tsc_pkg::COUNT_W-1:0]   out_lines_seen,
  output logic [tsc_pkg::COUNT_W-1:0]   out_words_seen,
  output logic [tsc_pkg::COUNT_W-1:0]   out_vowels_seen,
  output logic [tsc_pkg::COUNT_W-1:0]   out_uppers_seen,
  output logic [tsc_pkg::LONG_W-1:0]    out_longest_length,
  output logic [tsc_pkg::BYTE_W-1:0]    out_word_char
);

  tsc_pkg::step_t       step;
  tsc_pkg::byte_class_t cls;
  logic                 word_close;
  logic                 out_valid_r, out_valid_nxt;

  assign in_ready = !out_valid_r || out_ready;

  always_comb begin
    step.fire    = in_valid && in_ready;
    step.is_byte = 1'b0;
    step.is_eos  = 1'b0;
    step.is_read = 1'b0;
    unique case (tsc_pkg::cmd_e_t'(in_command))
      tsc_pkg::CMD_BYTE: step.is_byte = 1'b1;
      tsc_pkg::CMD_EOS:  step.is_eos  = 1'b1;
      tsc_pkg::CMD_READ: step.is_read = 1'b1;
      tsc_pkg::CMD_NONE: step.is_byte = 1'b0;
      default:           step.is_byte = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step.fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  tsc_classify u_classify (
    .data_byte (in_data_byte),
    .cls       (cls)
  );

  tsc_counters u_counters (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .cls         (cls),
    .word_close  (word_close),
    .lines_seen  (out_lines_seen),
    .words_seen  (out_words_seen),
    .vowels_seen (out_vowels_seen),
    .uppers_seen (out_uppers_seen)
  );

  tsc_word_store #(
    .WORD_CAPACITY (WORD_CAPACITY)
  ) u_word_store (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .cls            (cls),
    .data_byte      (in_data_byte),
    .char_index     (in_char_index),
    .word_close     (word_close),
    .longest_length (out_longest_length),
    .word_char      (out_word_char)
  );

endmodule
